// File: design/scmc_pkg.sv
// Shared constants, codes and types of the serial command mode controller.
package scmc_pkg;

  localparam int LineCapacity = 32;
  localparam int LineAw       = $clog2(LineCapacity);

  localparam logic [7:0] CharCr = 8'd13;
  localparam logic [7:0] CharLf = 8'd10;

  localparam logic [7:0] CFG_RPM_LOWER  = 8'd0;
  localparam logic [7:0] CFG_RPM_UPPER  = 8'd1;
  localparam logic [7:0] CFG_SCAN       = 8'd2;
  localparam logic [7:0] CFG_LOCKOUT    = 8'd3;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    RESP_PONG      = 4'd0,
    RESP_MODE      = 4'd1,
    RESP_RPM_SET   = 4'd2,
    RESP_ARMED     = 4'd3,
    RESP_STOPPED   = 4'd4,
    RESP_STOP_SAME = 4'd5,
    RESP_PARSE_ERR = 4'd6,
    RESP_RANGE_ERR = 4'd7,
    RESP_BAD_RPM   = 4'd8,
    RESP_BAD_ARM   = 4'd9,
    RESP_UNKNOWN   = 4'd10,
    RESP_TOO_LONG  = 4'd11,
    RESP_BUTTON    = 4'd12
  } resp_t;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ARMED = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  typedef enum logic [2:0] {
    V_PING,
    V_MODE,
    V_RPM_OK,
    V_PARSE,
    V_RANGE,
    V_ARM,
    V_STOP,
    V_UNKNOWN
  } verdict_t;

  typedef struct packed {
    logic             done;
    verdict_t         verdict;
    logic [31:0]      req;
  } exec_res_t;

endpackage

// File: design/scmc_line_ram.sv
// Line store: one write port, one registered read port.
module scmc_line_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [scmc_pkg::LineAw-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic [scmc_pkg::LineAw-1:0] raddr,
  output logic [7:0]                  rdata
);
  import scmc_pkg::*;

  logic [7:0] mem [LineCapacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/scmc_line_exec.sv
// Line sequencer: walks the stored line, matches commands and parses the number.
module scmc_line_exec (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [scmc_pkg::LineAw-1:0] len,
  input  logic [15:0]                 lower,
  input  logic [15:0]                 upper,
  output logic [scmc_pkg::LineAw-1:0] raddr,
  input  logic [7:0]                  rdata,
  output scmc_pkg::exec_res_t         res
);
  import scmc_pkg::*;

  typedef enum logic [2:0] {
    E_IDLE = 3'b001,
    E_RUN  = 3'b010,
    E_FIN  = 3'b100
  } exec_state_t;

  typedef enum logic [5:0] {
    P_START = 6'b000001,
    P_WS    = 6'b000010,
    P_SIGN  = 6'b000100,
    P_DIG   = 6'b001000,
    P_TRAIL = 6'b010000,
    P_ERR   = 6'b100000
  } parse_state_t;

  localparam logic [55:0] WordPing = {"PING", 24'h0};
  localparam logic [55:0] WordMode = {"MODE?", 16'h0};
  localparam logic [55:0] WordArm  = {"ARM", 32'h0};
  localparam logic [55:0] WordStop = {"STOP", 24'h0};
  localparam logic [55:0] WordSet  = "SET_RPM";

  // True when the character at position i agrees with word s of length n,
  // or lies past the word.
  function automatic logic chr_ok(input logic [55:0] s, input int n,
                                  input logic [LineAw-1:0] i, input logic [7:0] c);
    logic ok;
    ok = (int'(i) >= n);
    for (int k = 0; k < 7; k++) begin
      if (k < n && int'(i) == k && c == s[55-8*k -: 8]) begin
        ok = 1'b1;
      end
    end
    return ok;
  endfunction

  exec_state_t        state;
  logic [LineAw-1:0]  rd_idx;
  logic [LineAw-1:0]  pidx;
  logic               dv;
  logic               m_ping, m_mode, m_arm, m_stop, m_pre;
  parse_state_t       pst;
  logic               neg;
  logic               over;
  logic [31:0]        mag;

  logic               blank, digit;
  logic [36:0]        mag37;
  logic [31:0]        mag_f;
  logic [31:0]        req;
  logic               parse_ok;
  logic signed [31:0] lo32, hi32;

  assign raddr = rd_idx;
  assign blank = (rdata == 8'd32) || (rdata >= 8'd9 && rdata <= 8'd13);
  assign digit = (rdata >= "0") && (rdata <= "9");
  assign mag37 = ({5'b0, mag} << 3) + ({5'b0, mag} << 1) + {33'b0, rdata[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      dv    <= 1'b0;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (start) begin
            state  <= E_RUN;
            rd_idx <= '0;
            dv     <= 1'b0;
            m_ping <= 1'b1;
            m_mode <= 1'b1;
            m_arm  <= 1'b1;
            m_stop <= 1'b1;
            m_pre  <= 1'b1;
            pst    <= P_START;
            neg    <= 1'b0;
            over   <= 1'b0;
            mag    <= '0;
          end
        end
        E_RUN: begin
          // Issue the next read while the previous byte is classified.
          if (rd_idx != len) begin
            rd_idx <= rd_idx + 1'b1;
            pidx   <= rd_idx;
            dv     <= 1'b1;
          end else begin
            dv <= 1'b0;
            if (!dv) begin
              state <= E_FIN;
            end
          end
          if (dv) begin
            m_ping <= m_ping & chr_ok(WordPing, 4, pidx, rdata);
            m_mode <= m_mode & chr_ok(WordMode, 5, pidx, rdata);
            m_arm  <= m_arm  & chr_ok(WordArm,  3, pidx, rdata);
            m_stop <= m_stop & chr_ok(WordStop, 4, pidx, rdata);
            m_pre  <= m_pre  & chr_ok(WordSet,  7, pidx, rdata);
            unique case (pst)
              P_START: begin
                if (pidx == LineAw'(7)) begin
                  pst <= (rdata == 8'd32) ? P_WS : P_ERR;
                end
              end
              P_WS: begin
                if (blank) begin
                  pst <= P_WS;
                end else if (rdata == "+" || rdata == "-") begin
                  neg <= (rdata == "-");
                  pst <= P_SIGN;
                end else if (digit) begin
                  pst <= P_DIG;
                  mag <= {28'b0, rdata[3:0]};
                end else begin
                  pst <= P_ERR;
                end
              end
              P_SIGN, P_DIG: begin
                if (digit) begin
                  pst <= P_DIG;
                  if (!over) begin
                    if (mag37 > 37'h0_8000_0000) begin
                      over <= 1'b1;
                    end else begin
                      mag <= mag37[31:0];
                    end
                  end
                end else if (pst == P_DIG && rdata == 8'd32) begin
                  pst <= P_TRAIL;
                end else begin
                  pst <= P_ERR;
                end
              end
              P_TRAIL: begin
                if (rdata != 8'd32) begin
                  pst <= P_ERR;
                end
              end
              P_ERR: pst <= P_ERR;
              default: pst <= P_ERR;
            endcase
          end
        end
        E_FIN: state <= E_IDLE;
        default: state <= E_IDLE;
      endcase
    end
  end

  always_comb begin
    mag_f = over ? 32'h8000_0000 : mag;
    if (neg) begin
      req = ~mag_f + 32'd1;
    end else if (mag_f == 32'h8000_0000) begin
      req = 32'h7FFF_FFFF;
    end else begin
      req = mag_f;
    end
    lo32     = {{16{lower[15]}}, lower};
    hi32     = {{16{upper[15]}}, upper};
    parse_ok = (pst == P_DIG) || (pst == P_TRAIL);

    res.done    = (state == E_FIN);
    res.req     = '0;
    if (len == LineAw'(4) && m_ping) begin
      res.verdict = V_PING;
    end else if (len == LineAw'(5) && m_mode) begin
      res.verdict = V_MODE;
    end else if (len >= LineAw'(7) && m_pre) begin
      if (!parse_ok) begin
        res.verdict = V_PARSE;
      end else begin
        res.req     = req;
        res.verdict = ($signed(req) < lo32 || $signed(req) > hi32) ? V_RANGE : V_RPM_OK;
      end
    end else if (len == LineAw'(3) && m_arm) begin
      res.verdict = V_ARM;
    end else if (len == LineAw'(4) && m_stop) begin
      res.verdict = V_STOP;
    end else begin
      res.verdict = V_UNKNOWN;
    end
  end

endmodule

// File: design/serial_command_mode_controller.sv
// Top level of the serial command mode controller.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tuser kind, s_tdata byte/time/level
//  m_      | out       | m_tvalid/m_tready  | m_tuser response, m_tdata mode..presses
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// A byte that is stored, a time sample and an overlong byte are handled as they are taken.
// A CR or LF on a line of n characters walks the line store one read a cycle
// through the single read port of the line store, and the result is registered once
// the walk ends. No input is taken while a line runs.
// Reset is synchronous; the line store needs no clearing pass.
// A new transfer is taken while a waiting result is handed over in that cycle.
module serial_command_mode_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // rx_byte[7:0], now_ms[39:8], button_level[40], zero
  input  logic         s_tuser,   // item kind, byte or sample
  output logic         m_tvalid,
  input  logic         m_tready,
  // mode[1:0], target_speed[17:2], requested_speed[49:18], mode_changes[81:50],
  // presses[113:82], zero
  output logic [119:0] m_tdata,
  output logic [3:0]   m_tuser,   // response
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import scmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } top_state_t;

  top_state_t        state, state_next;
  logic [LineAw-1:0] len, len_next;
  logic [1:0]        mode, mode_next;
  logic [15:0]       target, target_next;
  logic [31:0]       chg, chg_next;
  logic [31:0]       prs, prs_next;
  logic [31:0]       last_scan, last_scan_next;
  logic [31:0]       last_press, last_press_next;
  logic              prev_level, prev_level_next;

  logic [15:0]       rpm_lower, rpm_upper, scan_period, lockout;

  resp_t             out_resp;
  logic [1:0]        out_mode;
  logic [15:0]       out_tgt;
  logic [31:0]       out_req, out_chg, out_prs;

  logic              accept;
  logic              emit;
  resp_t             resp;
  logic [31:0]       req;
  logic              start;
  logic              wr_en;
  logic [7:0]        rx_byte;
  logic [31:0]       now_ms;
  logic              level;
  logic [LineAw-1:0] raddr;
  logic [7:0]        rdata;
  exec_res_t         res;

  assign rx_byte  = s_tdata[7:0];
  assign now_ms   = s_tdata[39:8];
  assign level    = s_tdata[40];
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign cfg_ready = 1'b1;

  assign m_tuser = out_resp;
  assign m_tdata = {6'b0, out_prs, out_chg, out_req, out_tgt, out_mode};

  scmc_line_ram u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len),
    .wdata (rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  scmc_line_exec u_exec (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .len   (len),
    .lower (rpm_lower),
    .upper (rpm_upper),
    .raddr (raddr),
    .rdata (rdata),
    .res   (res)
  );

  always_comb begin
    state_next      = state;
    len_next        = len;
    mode_next       = mode;
    target_next     = target;
    chg_next        = chg;
    prs_next        = prs;
    last_scan_next  = last_scan;
    last_press_next = last_press;
    prev_level_next = prev_level;
    emit            = 1'b0;
    resp            = RESP_PONG;
    req             = '0;
    start           = 1'b0;
    wr_en           = 1'b0;

    if (state == S_IDLE && accept) begin
      if (s_tuser == KIND_BYTE) begin
        if (rx_byte == CharCr || rx_byte == CharLf) begin
          // Empty lines are dropped silently.
          if (len != '0) begin
            start      = 1'b1;
            state_next = S_EXEC;
          end
        end else if (len < LineAw'(LineCapacity - 1)) begin
          wr_en    = 1'b1;
          len_next = len + 1'b1;
        end else begin
          len_next = '0;
          emit     = 1'b1;
          resp     = RESP_TOO_LONG;
        end
      end else if ((now_ms - last_scan) >= {16'b0, scan_period}) begin
        last_scan_next  = now_ms;
        prev_level_next = level;
        if (!prev_level && level && (now_ms - last_press) >= {16'b0, lockout}) begin
          last_press_next = now_ms;
          prs_next        = prs + 32'd1;
          chg_next        = chg + 32'd1;
          unique case (mode)
            MODE_IDLE:  mode_next = MODE_ARMED;
            MODE_ARMED: mode_next = MODE_RUN;
            default:    mode_next = MODE_IDLE;
          endcase
          emit = 1'b1;
          resp = RESP_BUTTON;
        end
      end
    end

    if (state == S_EXEC && res.done) begin
      state_next = S_IDLE;
      len_next   = '0;
      emit       = 1'b1;
      unique case (res.verdict)
        V_PING:  resp = RESP_PONG;
        V_MODE:  resp = RESP_MODE;
        V_PARSE: resp = RESP_PARSE_ERR;
        V_RANGE: begin
          resp = RESP_RANGE_ERR;
          req  = res.req;
        end
        V_RPM_OK: begin
          req = res.req;
          if (mode == MODE_IDLE) begin
            resp = RESP_BAD_RPM;
          end else begin
            resp        = RESP_RPM_SET;
            target_next = res.req[15:0];
          end
        end
        V_ARM: begin
          if (mode != MODE_IDLE) begin
            resp = RESP_BAD_ARM;
          end else begin
            resp      = RESP_ARMED;
            mode_next = MODE_ARMED;
            chg_next  = chg + 32'd1;
          end
        end
        V_STOP: begin
          target_next = '0;
          if (mode == MODE_IDLE) begin
            resp = RESP_STOP_SAME;
          end else begin
            resp      = RESP_STOPPED;
            mode_next = MODE_IDLE;
            chg_next  = chg + 32'd1;
          end
        end
        default: resp = RESP_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      len        <= '0;
      mode       <= MODE_IDLE;
      target     <= '0;
      chg        <= '0;
      prs        <= '0;
      last_scan  <= '0;
      last_press <= '0;
      prev_level <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      len        <= len_next;
      mode       <= mode_next;
      target     <= target_next;
      chg        <= chg_next;
      prs        <= prs_next;
      last_scan  <= last_scan_next;
      last_press <= last_press_next;
      prev_level <= prev_level_next;
      // Load a fresh result, or drop the one just taken.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload carries the state after the step.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_resp <= resp;
      out_mode <= mode_next;
      out_tgt  <= target_next;
      out_req  <= req;
      out_chg  <= chg_next;
      out_prs  <= prs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_lower   <= 16'hF060;
      rpm_upper   <= 16'd4000;
      scan_period <= 16'd10;
      lockout     <= 16'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RPM_LOWER: rpm_lower   <= cfg_data;
        CFG_RPM_UPPER: rpm_upper   <= cfg_data;
        CFG_SCAN:      scan_period <= cfg_data;
        CFG_LOCKOUT:   lockout     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: design/scmc_checker.sv
// Port checker for the serial command mode controller, bound to the top level.
module scmc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [119:0] m_tdata,
  input logic [3:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_resp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= 4'd12)
    else $error("response code out of range");

  a_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("mode field holds unused code");

  a_req: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != 4'd2 && m_tuser != 4'd7 && m_tuser != 4'd8
    |-> m_tdata[49:18] == 32'd0)
    else $error("requested speed not zero");

endmodule

bind serial_command_mode_controller scmc_checker u_scmc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// File: tb/serial_command_mode_controller_test.sv
// Self-checking testbench of the serial command mode controller.
module serial_command_mode_controller_test;
  import scmc_pkg::*;

  // One expected response, with the fields in the order they leave the block.
  typedef struct {
    resp_t       resp;
    logic [1:0]  mode;
    logic [15:0] target;
    logic [31:0] req;
    logic [31:0] changes;
    logic [31:0] presses;
  } reply_t;

  // Controller model plus the queue of replies still owed by the block.
  class reply_board;
    reply_t      pending[$];
    int          errors;
    int          checked;
    logic [7:0]  line_buf[LineCapacity];
    int          line_len;
    logic [1:0]  mode;
    logic [15:0] target;
    logic [31:0] changes;
    logic [31:0] presses;
    logic [31:0] last_scan;
    logic [31:0] last_press;
    logic        prev_level;
    logic [15:0] lim_lo;
    logic [15:0] lim_hi;
    logic [15:0] scan_period;
    logic [15:0] lockout;

    function new();
      errors = 0;
      checked = 0;
      line_len = 0;
      mode = MODE_IDLE;
      target = 0;
      changes = 0;
      presses = 0;
      last_scan = 0;
      last_press = 0;
      prev_level = 0;
      lim_lo = 16'hF060;
      lim_hi = 16'd4000;
      scan_period = 16'd10;
      lockout = 16'd50;
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        CFG_RPM_LOWER: lim_lo = val;
        CFG_RPM_UPPER: lim_hi = val;
        CFG_SCAN:      scan_period = val;
        CFG_LOCKOUT:   lockout = val;
        default: ;
      endcase
    endfunction

    function void push(resp_t r, logic [31:0] req);
      reply_t e;
      e.resp = r;
      e.mode = mode;
      e.target = target;
      e.req = req;
      e.changes = changes;
      e.presses = presses;
      pending.push_back(e);
    endfunction

    function bit line_equals(string s);
      if (line_len != s.len()) return 0;
      for (int i = 0; i < s.len(); i++)
        if (line_buf[i] != s[i]) return 0;
      return 1;
    endfunction

    function bit blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Parse the SET_RPM argument; returns 0 on a syntax error.
    function bit parse_speed(output logic signed [31:0] val);
      int i;
      bit neg;
      int digits;
      longint unsigned mag;
      longint v;
      i = 7;
      neg = 0;
      digits = 0;
      mag = 0;
      val = 0;
      if (i >= line_len || line_buf[i] != 8'd32) return 0;
      while (i < line_len && blank(line_buf[i])) i++;
      if (i < line_len && (line_buf[i] == "+" || line_buf[i] == "-")) begin
        neg = line_buf[i] == "-";
        i++;
      end
      while (i < line_len && line_buf[i] >= "0" && line_buf[i] <= "9") begin
        if (mag <= 64'h1_0000_0000) mag = mag * 10 + (line_buf[i] - "0");
        digits++;
        i++;
      end
      if (digits == 0) return 0;
      while (i < line_len && line_buf[i] == 8'd32) i++;
      if (i != line_len) return 0;
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      v = neg ? -longint'(mag) : longint'(mag);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      val = v[31:0];
      return 1;
    endfunction

    function void run_command();
      logic signed [31:0] req;
      bit is_rpm;
      string prefix;
      prefix = "SET_RPM";
      is_rpm = line_len >= 7;
      for (int i = 0; i < 7 && is_rpm; i++)
        if (line_buf[i] != prefix[i]) is_rpm = 0;
      if (line_equals("PING")) push(RESP_PONG, 0);
      else if (line_equals("MODE?")) push(RESP_MODE, 0);
      else if (is_rpm) begin
        if (!parse_speed(req)) push(RESP_PARSE_ERR, 0);
        else if (req < $signed(lim_lo) || req > $signed(lim_hi)) push(RESP_RANGE_ERR, req);
        else if (mode == MODE_IDLE) push(RESP_BAD_RPM, req);
        else begin
          target = req[15:0];
          push(RESP_RPM_SET, req);
        end
      end else if (line_equals("ARM")) begin
        if (mode != MODE_IDLE) push(RESP_BAD_ARM, 0);
        else begin
          mode = MODE_ARMED;
          changes++;
          push(RESP_ARMED, 0);
        end
      end else if (line_equals("STOP")) begin
        target = 0;
        if (mode == MODE_IDLE) push(RESP_STOP_SAME, 0);
        else begin
          mode = MODE_IDLE;
          changes++;
          push(RESP_STOPPED, 0);
        end
      end else push(RESP_UNKNOWN, 0);
    endfunction

    // Note one accepted input transfer and queue any reply it causes.
    function void note_item(logic kind, logic [7:0] b, logic [31:0] now, logic lvl);
      if (kind == KIND_BYTE) begin
        if (b == CharCr || b == CharLf) begin
          if (line_len > 0) run_command();
          line_len = 0;
        end else if (line_len < LineCapacity - 1) begin
          line_buf[line_len] = b;
          line_len++;
        end else begin
          line_len = 0;
          push(RESP_TOO_LONG, 0);
        end
      end else begin
        if (now - last_scan < {16'd0, scan_period}) return;
        last_scan = now;
        if (!prev_level && lvl && now - last_press >= {16'd0, lockout}) begin
          last_press = now;
          presses++;
          case (mode)
            MODE_IDLE:  mode = MODE_ARMED;
            MODE_ARMED: mode = MODE_RUN;
            default:    mode = MODE_IDLE;
          endcase
          changes++;
          push(RESP_BUTTON, 0);
        end
        prev_level = lvl;
      end
    endfunction

    // Compare one reply from the block with the oldest one owed.
    function void check_reply(logic [3:0] resp, logic [119:0] d);
      reply_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply resp=%0d data=%h", $time, resp, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (resp !== e.resp) begin
        $display("%0t: response expected %0d actual %0d", $time, e.resp, resp);
        errors++;
      end
      if (d[1:0] !== e.mode) begin
        $display("%0t: mode expected %0d actual %0d", $time, e.mode, d[1:0]);
        errors++;
      end
      if (d[17:2] !== e.target) begin
        $display("%0t: target expected %0d actual %0d", $time,
                 $signed(e.target), $signed(d[17:2]));
        errors++;
      end
      if (d[49:18] !== e.req) begin
        $display("%0t: requested expected %0d actual %0d", $time,
                 $signed(e.req), $signed(d[49:18]));
        errors++;
      end
      if (d[81:50] !== e.changes) begin
        $display("%0t: changes expected %0d actual %0d", $time, e.changes, d[81:50]);
        errors++;
      end
      if (d[113:82] !== e.presses) begin
        $display("%0t: presses expected %0d actual %0d", $time, e.presses, d[113:82]);
        errors++;
      end
      if (d[119:114] !== 6'd0) begin
        $display("%0t: pad bits expected 0 actual %h", $time, d[119:114]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [47:0]  s_tdata = 0;
  logic         s_tuser = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [119:0] m_tdata;
  logic [3:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = 0;
  logic [15:0]  cfg_data = 0;

  reply_board   board = new();
  bit           calm = 0;       // no idling on either side while set
  int           n_items = 0;
  int           n_cfg = 0;
  longint       cycles = 0;
  logic [31:0]  clock_ms = 0;   // running time for samples

  serial_command_mode_controller u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run as failed once the cycle count passes its limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receive side: check each reply transfer, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_reply(m_tuser, m_tdata);
    m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  // Offer one item and hold it until the block takes the transfer.
  task automatic send_item(logic kind, logic [7:0] b, logic [31:0] now, logic lvl);
    if (!calm && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'd0, lvl, now, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(kind, b, now, lvl);
    n_items++;
  endtask

  // Hold the sender until every owed reply is back and the block has settled.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
    n_cfg++;
  endtask

  task automatic set_limits(logic [15:0] lo, logic [15:0] hi, logic [15:0] scan,
                            logic [15:0] lock);
    write_reg(CFG_RPM_LOWER, lo);
    write_reg(CFG_RPM_UPPER, hi);
    write_reg(CFG_SCAN, scan);
    write_reg(CFG_LOCKOUT, lock);
  endtask

  // Send a line and end it with CR or LF at random.
  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i], 0, 0);
    send_item(KIND_BYTE, $urandom_range(0, 1) ? CharCr : CharLf, 0, 0);
  endtask

  task automatic sample(int unsigned step, logic lvl);
    clock_ms = clock_ms + step;
    send_item(KIND_SAMPLE, 8'd0, clock_ms, lvl);
  endtask

  // One press and release, spaced well past scan and lockout at reset values.
  task automatic press_once();
    sample(60, 1'b1);
    sample(60, 1'b0);
  endtask

  function automatic string digit_run(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string speed_line();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0, 1, 2: return $sformatf("SET_RPM %0d", $signed(16'($urandom_range(0, 9000))) % 5000);
      3: return $sformatf("SET_RPM %0d", $signed($urandom));
      4: return $sformatf("SET_RPM  \t+%0d  ", $urandom_range(0, 40000));
      5: return {"SET_RPM -", digit_run($urandom_range(9, 20))};
      6: return "SET_RPM";
      7: return $sformatf("SET_RPM%0d", $urandom_range(0, 99));
      8: return $sformatf("SET_RPM %0dx", $urandom_range(0, 99));
      default: return $urandom_range(0, 1) ? "SET_RPM -" : "SET_RPM 12 3";
    endcase
  endfunction

  // Random command line, mostly well formed.
  task automatic random_line();
    string s;
    int k;
    int n;
    k = $urandom_range(0, 19);
    case (k)
      0, 1:    s = "PING";
      2:       s = "MODE?";
      3, 4, 5: s = "ARM";
      6, 7:    s = "STOP";
      8, 9, 10, 11, 12: s = speed_line();
      13:      s = "PIN";
      14:      s = "STOPX";
      default: s = "";
    endcase
    if (k >= 15) begin
      n = (k == 19) ? $urandom_range(31, 40) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CharCr || c == CharLf) c = 8'd0;
        send_item(KIND_BYTE, c, 0, 0);
      end
      if (n < 31 || $urandom_range(0, 1))
        send_item(KIND_BYTE, $urandom_range(0, 1) ? CharCr : CharLf, 0, 0);
    end else begin
      send_line(s);
      if ($urandom_range(0, 9) == 0) send_item(KIND_BYTE, CharLf, 0, 0);
    end
  endtask

  // Burst of time samples with a random level; sometimes jump the clock.
  task automatic random_samples();
    int n;
    n = $urandom_range(2, 8);
    if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
    for (int i = 0; i < n; i++)
      sample($urandom_range(0, 3) == 0 ? $urandom_range(0, 9) : $urandom_range(5, 120),
             $urandom_range(0, 1));
  endtask

  initial begin
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each command, its refusals and the parse corner cases.
    send_line("PING");
    send_line("MODE?");
    send_line("SET_RPM 5");
    send_line("STOP");
    send_line("ARM");
    send_line("ARM");
    send_line("SET_RPM 4000");
    send_line("SET_RPM -4001");
    send_line("SET_RPM  \t-4000 ");
    send_line("SET_RPM 99999999999999");
    send_line("SET_RPM -99999999999999");
    send_line("SET_RPM");
    send_line("SET_RPM +");
    send_line("SET_RPM 1 2");
    send_item(KIND_BYTE, CharCr, 0, 0);
    send_item(KIND_BYTE, 8'd0, 0, 0);
    send_item(KIND_BYTE, 8'hFF, 0, 0);
    send_item(KIND_BYTE, CharLf, 0, 0);
    for (int i = 0; i < 32; i++) send_item(KIND_BYTE, "A", 0, 0);
    send_line("STOP");
    send_line("STOP");
    press_once();
    press_once();
    press_once();
    sample(1, 1'b1);
    clock_ms = 32'hFFFF_FFF0;
    press_once();

    // Wait for every reply before going on.
    drain();

    // Random phases under different register settings, extremes included.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_limits(16'hF060, 16'd4000, 16'd10, 16'd50);
        1: set_limits(16'h8000, 16'h7FFF, 16'd0, 16'd0);
        2: set_limits(16'd100, 16'hFF9C, 16'd3, 16'd20);
        3: set_limits(16'hFC18, 16'd1000, 16'hFFFF, 16'hFFFF);
        4: set_limits(16'($urandom), 16'($urandom), 16'($urandom_range(0, 30)),
                      16'($urandom_range(0, 100)));
        default: set_limits(16'h8000, 16'd0, 16'd1, 16'd60);
      endcase
      calm = (phase == 2);
      repeat (40) begin
        if ($urandom_range(0, 2) == 0) random_samples();
        else random_line();
      end
      if (phase == 3) begin
        clock_ms = $urandom;
        repeat (4) press_once();
      end
      calm = 0;
    end
    while (n_items < 950) begin
      if ($urandom_range(0, 2) == 0) random_samples();
      else random_line();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d items and %0d register writes; %0d replies checked.",
             n_items, n_cfg, board.checked);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
